// ===== rtl/core/lobm_pkg.sv =====
// Package for the limit order book matcher: sizes, codes and payload types.
// Used by limit_order_book_matcher; depends on nothing.
package lobm_pkg;
	localparam int ENTRIES  = 32;
	localparam int PRODUCTS = 16;
	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int PROD_W   = 4;
	localparam int TC_IDX_W = (PRODUCTS > 1) ? $clog2(PRODUCTS) : 1;

	localparam logic [1:0] KIND_TRADE  = 2'd0;
	localparam logic [1:0] KIND_MARKET = 2'd1;
	localparam logic [1:0] KIND_CANCEL = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	localparam logic [1:0] FS_FILLED   = 2'd0;
	localparam logic [1:0] FS_PARTIAL  = 2'd1;
	localparam logic [1:0] FS_CANCELED = 2'd2;

	localparam logic OP_NEW    = 1'b0;
	localparam logic OP_CANCEL = 1'b1;
	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;
	localparam logic METHOD_LIMIT  = 1'b0;
	localparam logic METHOD_MARKET = 1'b1;

	typedef struct packed {
		logic        op;
		logic [47:0] oid;
		logic [3:0]  product;
		logic        side;
		logic        method;
		logic [39:0] limit_px;
		logic [31:0] quantity;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  product_out;
		logic [47:0] buy_order;
		logic [47:0] sell_order;
		logic [39:0] fill_px;
		logic [31:0] amount;
		logic [31:0] canceled_amount;
		logic [31:0] trade_number;
		logic [1:0]  fill_status;
		logic        removed;
		logic        last;
	} out_item_t;

	function automatic logic [1:0] status_of(logic [31:0] qty, logic [31:0] rem);
		if (rem == 32'd0) return FS_FILLED;
		if (qty != rem) return FS_PARTIAL;
		return FS_CANCELED;
	endfunction
endpackage

// ===== rtl/core/limit_order_book_matcher.sv =====
// Top level of the limit order book matcher: order table, scan sequencer
// and result register. Depends on lobm_pkg.
//
//   channel   direction  handshake          payload
//   in        to block   in_valid/in_stall  lobm_pkg::in_item_t
//   out       from block out_valid/out_stall lobm_pkg::out_item_t
//
// A cancel makes one pass over the table and then emits its closing result.
// A new order makes one table pass and one trade step for each trade, a closing
// pass unless its last trade fills it, and then finishes; a zero quantity order
// skips the table passes.
// Reset clears valid bits, the arrival counter and the trade counters.
// A result waits in a pending register; the sequencer holds while that
// register is full and out_stall blocks the result register.
module limit_order_book_matcher (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lobm_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output lobm_pkg::out_item_t  out_item
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_TRADE = 3'd2;
	localparam logic [2:0] ST_FINAL = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	localparam logic [lobm_pkg::IDX_W:0] LAST_IDX = (lobm_pkg::IDX_W + 1)'(lobm_pkg::ENTRIES - 1);
	localparam logic [lobm_pkg::IDX_W:0] SCAN_STEP = (lobm_pkg::IDX_W + 1)'(1);

	logic [2:0] state_q;
	logic [lobm_pkg::ENTRIES-1:0] valid_q;
	logic        ent_side_q   [lobm_pkg::ENTRIES];
	logic [3:0]  ent_prod_q   [lobm_pkg::ENTRIES];
	logic [39:0] ent_price_q  [lobm_pkg::ENTRIES];
	logic [31:0] ent_rem_q    [lobm_pkg::ENTRIES];
	logic [47:0] ent_id_q     [lobm_pkg::ENTRIES];
	logic [31:0] ent_arr_q    [lobm_pkg::ENTRIES];
	logic [31:0] arrival_q;
	logic [31:0] trade_cnt_q  [lobm_pkg::PRODUCTS];

	lobm_pkg::in_item_t cur_q;
	logic [3:0]  prod_q;
	logic [31:0] left_q;
	logic [lobm_pkg::IDX_W:0] scan_q;
	logic        found_q;
	logic [lobm_pkg::IDX_W-1:0] best_q;
	logic        free_found_q;
	logic [lobm_pkg::IDX_W-1:0] free_q;
	logic        removed_q;
	logic        pend_q;
	lobm_pkg::out_item_t pend_item_q;

	logic [lobm_pkg::IDX_W-1:0] si;
	logic        cand, better, is_free, hit_cancel;
	logic [31:0] age_i, age_b, q_trade, tc_next;
	logic [3:0]  in_prod;
	logic [lobm_pkg::TC_IDX_W-1:0] tci;
	logic        out_free, need_final, out_load;
	lobm_pkg::out_item_t tr_item;
	lobm_pkg::out_item_t fin_item;

	assign in_stall = (state_q != ST_IDLE);
	assign in_prod = 4'(32'(in_item.product) % lobm_pkg::PRODUCTS);
	assign si = scan_q[lobm_pkg::IDX_W-1:0];
	assign tci = lobm_pkg::TC_IDX_W'(prod_q);

	// One compare unit looks at the entry under the scan pointer.
	always_comb begin
		cand = valid_q[si] && ent_prod_q[si] == prod_q && ent_side_q[si] != cur_q.side &&
			((cur_q.side == lobm_pkg::SIDE_BUY) ? (ent_price_q[si] <= cur_q.limit_px)
				: (ent_price_q[si] >= cur_q.limit_px));
		age_i = arrival_q - ent_arr_q[si];
		age_b = arrival_q - ent_arr_q[best_q];
		if (ent_price_q[si] != ent_price_q[best_q])
			better = (cur_q.side == lobm_pkg::SIDE_BUY) ? (ent_price_q[si] < ent_price_q[best_q])
				: (ent_price_q[si] > ent_price_q[best_q]);
		else
			better = age_i > age_b;
		is_free = !valid_q[si];
		hit_cancel = valid_q[si] && ent_prod_q[si] == prod_q && ent_id_q[si] == cur_q.oid;
		q_trade = (left_q < ent_rem_q[best_q]) ? left_q : ent_rem_q[best_q];
		tc_next = trade_cnt_q[tci] + 32'd1;

		out_free = !out_valid || !out_stall;
		need_final = (cur_q.op == lobm_pkg::OP_CANCEL) ||
			(cur_q.method == lobm_pkg::METHOD_MARKET) ||
			(left_q != 32'd0 && !free_found_q);
		out_load = pend_q && out_free && ((state_q == ST_TRADE) ||
			(state_q == ST_FINAL && need_final) || (state_q == ST_EMIT));

		tr_item.kind = lobm_pkg::KIND_TRADE;
		tr_item.product_out = prod_q;
		tr_item.buy_order = (cur_q.side == lobm_pkg::SIDE_BUY) ? cur_q.oid : ent_id_q[best_q];
		tr_item.sell_order = (cur_q.side == lobm_pkg::SIDE_BUY) ? ent_id_q[best_q] : cur_q.oid;
		tr_item.fill_px = ent_price_q[best_q];
		tr_item.amount = q_trade;
		tr_item.canceled_amount = '0;
		tr_item.trade_number = tc_next;
		tr_item.fill_status = lobm_pkg::FS_FILLED;
		tr_item.removed = 1'b0;
		// Whether a trade is the last result is only known once the order finishes.
		tr_item.last = 1'b0;

		fin_item.product_out = prod_q;
		fin_item.buy_order = cur_q.oid;
		fin_item.sell_order = '0;
		fin_item.fill_px = '0;
		fin_item.trade_number = '0;
		fin_item.last = 1'b1;
		if (cur_q.op == lobm_pkg::OP_CANCEL) begin
			fin_item.kind = lobm_pkg::KIND_CANCEL;
			fin_item.amount = '0;
			fin_item.canceled_amount = '0;
			fin_item.fill_status = lobm_pkg::FS_FILLED;
			fin_item.removed = removed_q;
		end else begin
			fin_item.kind = (cur_q.method == lobm_pkg::METHOD_MARKET) ?
				lobm_pkg::KIND_MARKET : lobm_pkg::KIND_REJECT;
			fin_item.amount = cur_q.quantity - left_q;
			fin_item.canceled_amount = left_q;
			fin_item.fill_status = lobm_pkg::status_of(cur_q.quantity, left_q);
			fin_item.removed = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			arrival_q <= '0;
			for (int p = 0; p < lobm_pkg::PRODUCTS; p++) trade_cnt_q[p] <= '0;
			out_valid <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			out_valid <= out_load || (out_valid && out_stall);
			if (out_load) out_item <= pend_item_q;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cur_q <= in_item;
						prod_q <= in_prod;
						left_q <= in_item.quantity;
						scan_q <= '0;
						found_q <= 1'b0;
						free_found_q <= 1'b0;
						removed_q <= 1'b0;
						if (in_item.op == lobm_pkg::OP_NEW && in_item.quantity == 32'd0)
							state_q <= ST_FINAL;
						else
							state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cur_q.op == lobm_pkg::OP_CANCEL) begin
						if (hit_cancel) begin
							valid_q[si] <= 1'b0;
							removed_q <= 1'b1;
						end
					end else begin
						if (cand && (!found_q || better)) begin
							found_q <= 1'b1;
							best_q <= si;
						end
						if (is_free && !free_found_q) begin
							free_found_q <= 1'b1;
							free_q <= si;
						end
					end
					scan_q <= scan_q + SCAN_STEP;
					if (scan_q == LAST_IDX) begin
						if (cur_q.op == lobm_pkg::OP_CANCEL) state_q <= ST_FINAL;
						else state_q <= (found_q || cand) ? ST_TRADE : ST_FINAL;
					end
				end
				ST_TRADE: begin
					// An earlier trade still pending moves to the result register first.
					if (!pend_q || out_free) begin
						pend_q <= 1'b1;
						pend_item_q <= tr_item;
						trade_cnt_q[tci] <= tc_next;
						ent_rem_q[best_q] <= ent_rem_q[best_q] - q_trade;
						if (ent_rem_q[best_q] == q_trade) valid_q[best_q] <= 1'b0;
						left_q <= left_q - q_trade;
						scan_q <= '0;
						found_q <= 1'b0;
						free_found_q <= 1'b0;
						state_q <= (left_q == q_trade) ? ST_FINAL : ST_SCAN;
					end
				end
				ST_FINAL: begin
					if (need_final) begin
						if (!pend_q || out_free) begin
							pend_q <= 1'b1;
							pend_item_q <= fin_item;
							state_q <= ST_EMIT;
						end
					end else begin
						// A limit order with no closing result ends on its last trade.
						if (pend_q) pend_item_q.last <= 1'b1;
						// The closing scan found a free slot for the remainder.
						if (left_q != 32'd0) begin
							valid_q[free_q] <= 1'b1;
							ent_side_q[free_q] <= cur_q.side;
							ent_prod_q[free_q] <= prod_q;
							ent_price_q[free_q] <= cur_q.limit_px;
							ent_rem_q[free_q] <= left_q;
							ent_id_q[free_q] <= cur_q.oid;
							ent_arr_q[free_q] <= arrival_q;
							arrival_q <= arrival_q + 32'd1;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!pend_q) state_q <= ST_IDLE;
					else if (out_free) begin
						pend_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("busy but not stalling");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_item)))
		else $error("result changed under stall");
	a_trade_amount: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.kind == lobm_pkg::KIND_TRADE) |-> (out_item.amount != 32'd0))
		else $error("trade of zero quantity");
	a_trade_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRADE) |-> found_q)
		else $error("trade without a best entry");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_q)
		else $error("result left pending while idle");
endmodule
